// ===== design/lmt_pkg.sv =====
// lmt_pkg: shared types and fixed constants of the local mean threshold block.
// No dependencies; imported by local_mean_threshold_core.
package lmt_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int PIX_W       = 8;
   localparam int WINDOW      = 9;
   localparam int SLOTS       = WINDOW - 1;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int BACK        = (WINDOW - 1) / 2;
   localparam int ROW_W       = 10;
   localparam int ROWLEN_W    = 9;
   localparam int OFFSET_W    = 8;
   localparam int COLSUM_W    = 12;
   localparam int WSUM_W      = 15;

   // floor(x / 81) = (x * RECIP) >> RECIP_SHIFT, exact for any 15-bit x
   localparam int RECIP_W     = 15;
   localparam int RECIP_SHIFT = 21;
   localparam logic [RECIP_W-1:0] RECIP = 15'd25891;
   localparam int PROD_W      = WSUM_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

   localparam logic [PIX_W-1:0] PIX_ONE  = 8'd255;
   localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_LENGTH       = 2'd0,
      CSR_ROW_COUNT        = 2'd1,
      CSR_THRESHOLD_OFFSET = 2'd2
   } csr_index_type;

   localparam logic [ROWLEN_W-1:0] ROW_LENGTH_RESET = 9'd188;
   localparam logic [ROW_W-1:0]    ROW_COUNT_RESET  = 10'd120;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET     = 8'd10;

endpackage

// ===== design/lmt_ram.sv =====
// lmt_ram: generic single-write, single-read synchronous RAM, registered read,
// read-before-write on a same-address collision. No dependencies.
module lmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/local_mean_threshold_core.sv =====
// local_mean_threshold_core: streaming 9x9 adaptive mean threshold, top level.
// Depends on lmt_pkg and lmt_ram.
//
// Takes one grey pixel per cycle while req_stall is low, in raster order, and returns
// one item per pixel: the binarised pixel four rows and four columns back, set to 255
// when it exceeds the 9x9 window mean (floored) minus threshold_offset, with
// window_valid low and all fields zero while the window still reaches past the top
// or left edge of the frame. Throughput is one item per cycle while rsp_stall is low.
// The eight previous rows sit in eight line RAMs, one per
// row slot; each item reads all eight at its column and writes its own pixel into its
// row's slot in the same cycle, so the one-port-per-RAM read sets the rate. The line
// store is not cleared after reset: the first eight rows of a frame read rows that may
// not exist yet, and their items carry window_valid low.
module local_mean_threshold_core
   import lmt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIX_W-1:0]       req_pixel,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIX_W-1:0]       rsp_binary_pixel,
   output logic                   rsp_window_valid,
   output logic [7:0]             rsp_center_col,
   output logic [ROW_W-1:0]       rsp_center_row,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = (COL_W + 1 > ROWLEN_W) ? COL_W + 1 : ROWLEN_W;

   // configuration
   logic [ROWLEN_W-1:0] row_length_ff, row_length_in;
   logic [ROW_W-1:0]    row_count_ff, row_count_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;

   // position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // pipeline occupancy
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, out_v_ff;
   logic s1_v_in, s2_v_in, s3_v_in, s4_v_in, s5_v_in, out_v_in;
   logic accept, move1, move2, move3, move4, move5;
   logic ld1ok, ld2ok, ld3ok, ld4ok, ld5ok, out_load;

   // stage payloads
   logic [PIX_W-1:0]    s1_pix_ff;
   logic                s1_win_ff, s2_win_ff, s3_win_ff, s4_win_ff, s5_win_ff;
   logic [COL_W-1:0]    s1_cc_ff, s2_cc_ff, s3_cc_ff, s4_cc_ff, s5_cc_ff;
   logic [ROW_W-1:0]    s1_cr_ff, s2_cr_ff, s3_cr_ff, s4_cr_ff, s5_cr_ff;
   logic [SLOT_W-1:0]   s1_csel_ff;
   logic [COLSUM_W-1:0] s2_colsum_ff;
   logic [PIX_W-1:0]    s2_centre_ff, s3_centre_ff, s4_centre_ff, s5_centre_ff;
   logic [PIX_W-1:0]    centre_sh_ff [BACK];
   logic [COLSUM_W-1:0] recent_ff [WINDOW];
   logic [WSUM_W-1:0]   s4_wsum_ff;
   logic [PROD_W-1:0]   s5_prod_ff;

   logic [PIX_W-1:0]    out_pix_ff;
   logic                out_win_ff;
   logic [7:0]          out_cc_ff;
   logic [ROW_W-1:0]    out_cr_ff;

   logic [PIX_W-1:0]    ram_rd [SLOTS];

   // combinational values
   logic [CMP_W-1:0]    len_eff, col_next;
   logic [ROW_W:0]      rows_eff, row_next;
   logic                win_now;
   logic [ROW_W-1:0]    cr_now;
   logic [COL_W-1:0]    cc_now;
   logic [COLSUM_W-1:0] colsum;
   logic [PIX_W-1:0]    cand;
   logic [WSUM_W-1:0]   wsum;
   logic [QUOT_W-1:0]   quot;
   logic                above;
   logic [COL_W+7:0]    cc_wide;

   // ---------------- handshake ----------------
   always_comb begin
      out_load = !out_v_ff || !rsp_stall;
      move5    = s5_v_ff && out_load;
      ld5ok    = !s5_v_ff || move5;
      move4    = s4_v_ff && ld5ok;
      ld4ok    = !s4_v_ff || move4;
      move3    = s3_v_ff && ld4ok;
      ld3ok    = !s3_v_ff || move3;
      move2    = s2_v_ff && ld3ok;
      ld2ok    = !s2_v_ff || move2;
      move1    = s1_v_ff && ld2ok;
      ld1ok    = !s1_v_ff || move1;
      accept   = req_valid && ld1ok;

      s1_v_in  = accept || (s1_v_ff && !move1);
      s2_v_in  = move1  || (s2_v_ff && !move2);
      s3_v_in  = move2  || (s3_v_ff && !move3);
      s4_v_in  = move3  || (s4_v_ff && !move4);
      s5_v_in  = move4  || (s5_v_ff && !move5);
      out_v_in = move5  || (out_v_ff && rsp_stall);
   end

   assign req_stall = !ld1ok;
   assign csr_ready = 1'b1;

   // ---------------- configuration ----------------
   always_comb begin
      row_length_in = row_length_ff;
      row_count_in  = row_count_ff;
      offset_in     = offset_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ROW_LENGTH:       row_length_in = csr_data[ROWLEN_W-1:0];
            CSR_ROW_COUNT:        row_count_in  = csr_data[ROW_W-1:0];
            CSR_THRESHOLD_OFFSET: offset_in     = csr_data[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- counters ----------------
   always_comb begin
      if (row_length_ff == '0) begin
         len_eff = CMP_W'(1);
      end else if (CMP_W'(row_length_ff) > CMP_W'(MAX_WIDTH)) begin
         len_eff = CMP_W'(MAX_WIDTH);
      end else begin
         len_eff = CMP_W'(row_length_ff);
      end
      rows_eff = (row_count_ff == '0) ? (ROW_W+1)'(1) : {1'b0, row_count_ff};
      col_next = CMP_W'(col_ff) + CMP_W'(1);
      row_next = {1'b0, row_ff} + (ROW_W+1)'(1);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next >= len_eff) begin
            col_in = '0;
            row_in = (row_next >= rows_eff) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end

      win_now = (row_ff >= ROW_W'(SLOTS)) && (col_ff >= COL_W'(SLOTS));
      cr_now  = row_ff - ROW_W'(BACK);
      cc_now  = col_ff - COL_W'(BACK);
   end

   // ---------------- line store ----------------
   for (genvar g = 0; g < SLOTS; g++) begin : g_line
      lmt_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (accept && (row_ff[SLOT_W-1:0] == SLOT_W'(g))),
         .wr_addr (col_ff),
         .wr_data (req_pixel),
         .rd_en   (accept),
         .rd_addr (col_ff),
         .rd_data (ram_rd[g])
      );
   end

   // ---------------- datapath ----------------
   always_comb begin
      colsum = COLSUM_W'(s1_pix_ff);
      for (int k = 0; k < SLOTS; k++) begin
         colsum = colsum + COLSUM_W'(ram_rd[k]);
      end
      cand = ram_rd[s1_csel_ff];

      wsum = '0;
      for (int k = 0; k < WINDOW; k++) begin
         wsum = wsum + WSUM_W'(recent_ff[k]);
      end

      quot  = s5_prod_ff[PROD_W-1:RECIP_SHIFT];
      // centre > mean - offset, kept unsigned
      above = ({2'b00, s5_centre_ff} + {2'b00, offset_ff}) > (PIX_W+2)'(quot);
      cc_wide = {8'b0, s5_cc_ff};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_pixel;
         s1_win_ff  <= win_now;
         s1_cc_ff   <= cc_now;
         s1_cr_ff   <= cr_now;
         s1_csel_ff <= cr_now[SLOT_W-1:0];
      end
      if (move1) begin
         s2_colsum_ff <= colsum;
         s2_centre_ff <= centre_sh_ff[BACK-1];
         centre_sh_ff[0] <= cand;
         for (int k = 1; k < BACK; k++) begin
            centre_sh_ff[k] <= centre_sh_ff[k-1];
         end
         s2_win_ff <= s1_win_ff;
         s2_cc_ff  <= s1_cc_ff;
         s2_cr_ff  <= s1_cr_ff;
      end
      if (move2) begin
         s3_centre_ff <= s2_centre_ff;
         s3_win_ff    <= s2_win_ff;
         s3_cc_ff     <= s2_cc_ff;
         s3_cr_ff     <= s2_cr_ff;
      end
      if (move3) begin
         s4_wsum_ff   <= wsum;
         s4_centre_ff <= s3_centre_ff;
         s4_win_ff    <= s3_win_ff;
         s4_cc_ff     <= s3_cc_ff;
         s4_cr_ff     <= s3_cr_ff;
      end
      if (move4) begin
         s5_prod_ff   <= s4_wsum_ff * RECIP;
         s5_centre_ff <= s4_centre_ff;
         s5_win_ff    <= s4_win_ff;
         s5_cc_ff     <= s4_cc_ff;
         s5_cr_ff     <= s4_cr_ff;
      end
      if (move5) begin
         out_win_ff <= s5_win_ff;
         out_pix_ff <= (s5_win_ff && above) ? PIX_ONE : PIX_ZERO;
         out_cc_ff  <= s5_win_ff ? cc_wide[7:0] : 8'd0;
         out_cr_ff  <= s5_win_ff ? s5_cr_ff : '0;
      end
   end

   // recent column sums are state with a defined reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW; k++) begin
            recent_ff[k] <= '0;
         end
      end else if (move2) begin
         recent_ff[0] <= s2_colsum_ff;
         for (int k = 1; k < WINDOW; k++) begin
            recent_ff[k] <= recent_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         row_count_ff  <= ROW_COUNT_RESET;
         offset_ff     <= OFFSET_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         s3_v_ff       <= 1'b0;
         s4_v_ff       <= 1'b0;
         s5_v_ff       <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         row_length_ff <= row_length_in;
         row_count_ff  <= row_count_in;
         offset_ff     <= offset_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         s1_v_ff       <= s1_v_in;
         s2_v_ff       <= s2_v_in;
         s3_v_ff       <= s3_v_in;
         s4_v_ff       <= s4_v_in;
         s5_v_ff       <= s5_v_in;
         out_v_ff      <= out_v_in;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_binary_pixel = out_pix_ff;
   assign rsp_window_valid = out_win_ff;
   assign rsp_center_col   = out_cc_ff;
   assign rsp_center_row   = out_cr_ff;

   // ---------------- assertions ----------------
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_v_ff)
      else $error("accepted item did not enter the RAM stage");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_v_ff && s2_v_ff && s3_v_ff && s4_v_ff && s5_v_ff && out_v_ff))
      else $error("input stalled with a free pipeline stage");

   a_col_steps: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (col_ff == '0 || col_ff == $past(col_ff) + COL_W'(1)))
      else $error("column counter skipped");

   a_centre_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_window_valid) |-> (rsp_center_row >= ROW_W'(BACK)))
      else $error("valid item decides a row above the window centre");

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for local_mean_threshold_core, 9x9 local mean binarisation.
// Depends on lmt_pkg and the core; an internal predictor tracks line store, sums and counters.
// Directed table first, then framed phases at extreme and random settings with random idling.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lmt_pkg::*;

   localparam int MAX_COLS      = MAX_WIDTH;
   localparam int CLOCK_PERIOD  = 12;
   localparam int RANDOM_ITEMS  = 400;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 24;
   localparam int LIMIT_CYCLES  = 700000;

   typedef struct packed {
      logic [PIX_W-1:0] binary_pixel;
      logic             window_valid;
      logic [7:0]       center_col;
      logic [ROW_W-1:0] center_row;
   } thresh_result_type;

   typedef enum logic [1:0] {
      STYLE_UNIFORM,
      STYLE_SMOOTH,
      STYLE_BINARY,
      STYLE_FLAT
   } pix_style_type;

   typedef struct packed {
      logic [9:0]    length;
      logic [9:0]    rows;
      logic [7:0]    offset;
      logic [11:0]   count;
      pix_style_type style;
   } phase_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel;
      logic              typed;
      thresh_result_type want;
   } opening_row_type;

   typedef struct packed {
      csr_index_type         idx;
      logic [CSR_DATA_W-1:0] value;
   } reg_write_type;

   localparam thresh_result_type BORDER = '0;

   // default settings straight after reset: every item sits on the top border
   localparam opening_row_type OPENING_ROWS [20] = '{
      '{8'h00, 1'b1, BORDER}, '{8'hFF, 1'b1, BORDER}, '{8'h01, 1'b1, BORDER},
      '{8'hFE, 1'b1, BORDER}, '{8'h55, 1'b1, BORDER}, '{8'hAA, 1'b1, BORDER},
      '{8'h0F, 1'b1, BORDER}, '{8'hF0, 1'b1, BORDER}, '{8'h80, 1'b1, BORDER},
      '{8'h7F, 1'b1, BORDER}, '{8'hFF, 1'b1, BORDER}, '{8'hFF, 1'b1, BORDER},
      '{8'h00, 1'b1, BORDER}, '{8'h00, 1'b1, BORDER}, '{8'h33, 1'b1, BORDER},
      '{8'hCC, 1'b1, BORDER}, '{8'h12, 1'b0, BORDER}, '{8'hED, 1'b0, BORDER},
      '{8'h40, 1'b0, BORDER}, '{8'hC0, 1'b0, BORDER}
   };

   localparam phase_type FRAME_PLAN [8] = '{
      '{10'd9,   10'd9,    8'd0,   12'd162,  STYLE_UNIFORM},
      '{10'd9,   10'd9,    8'd255, 12'd81,   STYLE_UNIFORM},
      '{10'd16,  10'd12,   8'd0,   12'd192,  STYLE_FLAT},
      '{10'd16,  10'd12,   8'd1,   12'd192,  STYLE_FLAT},
      '{10'd12,  10'd10,   8'd10,  12'd120,  STYLE_BINARY},
      '{10'd0,   10'd0,    8'd10,  12'd30,   STYLE_UNIFORM},
      '{10'd511, 10'd1,    8'd10,  12'd256,  STYLE_SMOOTH},
      '{10'd20,  10'd1023, 8'd10,  12'd200,  STYLE_UNIFORM}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIX_W-1:0]       req_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PIX_W-1:0]       rsp_binary_pixel;
   logic                   rsp_window_valid;
   logic [7:0]             rsp_center_col;
   logic [ROW_W-1:0]       rsp_center_row;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_ROW_LENGTH;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // predictor state
   bit [PIX_W-1:0]        line_mem [SLOTS][MAX_COLS];
   int unsigned           col_hist [WINDOW];
   int unsigned           col_pos = 0;
   int unsigned           row_pos = 0;
   logic [ROWLEN_W-1:0]   length_cfg = ROW_LENGTH_RESET;
   logic [ROW_W-1:0]      rows_cfg = ROW_COUNT_RESET;
   logic [OFFSET_W-1:0]   offset_cfg = OFFSET_RESET;

   thresh_result_type expected_pixels [$];
   int unsigned    mismatches = 0;
   int unsigned    pixels_fed = 0;
   int unsigned    items_checked = 0;
   int unsigned    windows_seen = 0;
   int unsigned    ones_seen = 0;
   int unsigned    settings_run = 0;
   int unsigned    feed_left = 0;
   bit             feed_brisk = 1'b0;
   bit             hold_off_request = 1'b0;
   logic [PIX_W-1:0] flat_level = '0;

   local_mean_threshold_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_binary_pixel(rsp_binary_pixel),
      .rsp_window_valid(rsp_window_valid),
      .rsp_center_col(rsp_center_col),
      .rsp_center_row(rsp_center_row),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   function automatic thresh_result_type predict_threshold(input logic [PIX_W-1:0] pix);
      int unsigned column_total, window_total, span, depth, cr, cc;
      int thr, centre;
      thresh_result_type res;
      column_total = pix;
      for (int k = 0; k < SLOTS; k++) column_total += line_mem[k][col_pos];
      for (int k = WINDOW - 1; k > 0; k--) col_hist[k] = col_hist[k-1];
      col_hist[0] = column_total;
      window_total = 0;
      for (int k = 0; k < WINDOW; k++) window_total += col_hist[k];
      res = '0;
      if (row_pos >= SLOTS && col_pos >= SLOTS) begin
         cr = row_pos - BACK;
         cc = col_pos - BACK;
         thr = int'(window_total / (WINDOW * WINDOW)) - int'(offset_cfg);
         centre = int'(line_mem[cr % SLOTS][cc]);
         res.binary_pixel = (centre > thr) ? PIX_ONE : PIX_ZERO;
         res.window_valid = 1'b1;
         res.center_col = cc[7:0];
         res.center_row = cr[ROW_W-1:0];
      end
      line_mem[row_pos % SLOTS][col_pos] = pix;
      span = (length_cfg == 0) ? 1 : ((length_cfg > MAX_COLS) ? MAX_COLS : length_cfg);
      depth = (rows_cfg == 0) ? 1 : rows_cfg;
      col_pos++;
      if (col_pos >= span) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= depth) row_pos = 0;
      end
      return res;
   endfunction

   function automatic logic [PIX_W-1:0] next_pixel(input pix_style_type style);
      case (style)
         STYLE_SMOOTH: return 8'((row_pos * 3 + col_pos * 2 + 40 + $urandom_range(0, 12)) % 256);
         STYLE_BINARY: return ($urandom_range(0, 1) != 0) ? PIX_ONE : PIX_ZERO;
         STYLE_FLAT:   return flat_level;
         default:      return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic log_failure(input string what, input thresh_result_type want,
                              input thresh_result_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: expected pix %0d valid %0d col %0d row %0d, got pix %0d valid %0d col %0d row %0d",
                  $time, what, want.binary_pixel, want.window_valid, want.center_col,
                  want.center_row, got.binary_pixel, got.window_valid, got.center_col,
                  got.center_row);
   endtask

   task automatic feed_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                             input thresh_result_type want);
      int unsigned gap;
      thresh_result_type predicted;
      if (feed_left == 0) begin
         feed_left = $urandom_range(20, 120);
         feed_brisk = ($urandom_range(0, 3) == 0);
      end
      feed_left--;
      gap = feed_brisk ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (req_stall);
      predicted = predict_threshold(pix);
      expected_pixels.push_back(typed ? want : predicted);
      pixels_fed++;
   endtask

   task automatic wait_drained();
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_registers(input reg_write_type writes [$]);
      foreach (writes[i]) begin
         csr_valid <= 1'b1;
         csr_index <= writes[i].idx;
         csr_data <= writes[i].value;
         do @(posedge clock); while (!csr_ready);
         case (writes[i].idx)
            CSR_ROW_LENGTH:       length_cfg = writes[i].value[ROWLEN_W-1:0];
            CSR_ROW_COUNT:        rows_cfg = writes[i].value[ROW_W-1:0];
            CSR_THRESHOLD_OFFSET: offset_cfg = writes[i].value[OFFSET_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // row length only changes on row 0, so every window later reads rows of this frame
   task automatic run_phase(input phase_type ph);
      reg_write_type writes [$];
      writes.push_back('{CSR_ROW_LENGTH, ph.length});
      writes.push_back('{CSR_ROW_COUNT, ph.rows});
      writes.push_back('{CSR_THRESHOLD_OFFSET, {2'b00, ph.offset}});
      write_registers(writes);
      flat_level = 8'($urandom_range(0, 255));
      settings_run++;
      for (int i = 0; i < ph.count; i++) feed_pixel(next_pixel(ph.style), 1'b0, BORDER);
      req_valid <= 1'b0;
      wait_drained();
      if (row_pos != 0) begin
         writes.delete();
         writes.push_back('{CSR_ROW_COUNT, CSR_DATA_W'(row_pos + 1)});
         write_registers(writes);
         while (row_pos != 0) feed_pixel(next_pixel(ph.style), 1'b0, BORDER);
         req_valid <= 1'b0;
         wait_drained();
      end
   endtask

   always @(posedge clock) begin
      thresh_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.binary_pixel = rsp_binary_pixel;
         got.window_valid = rsp_window_valid;
         got.center_col = rsp_center_col;
         got.center_row = rsp_center_row;
         items_checked++;
         if (got.window_valid === 1'b1) windows_seen++;
         if (got.binary_pixel === PIX_ONE) ones_seen++;
         if (expected_pixels.size() == 0) begin
            log_failure("unexpected item", BORDER, got);
         end else begin
            want = expected_pixels.pop_front();
            if (got.binary_pixel !== want.binary_pixel ||
                got.window_valid !== want.window_valid ||
                got.center_col !== want.center_col ||
                got.center_row !== want.center_row)
               log_failure("item differs", want, got);
         end
      end
   end

   initial begin : result_sink
      int unsigned hold, left;
      bit brisk;
      left = 0;
      brisk = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold = LONG_HOLD;
         end else begin
            if (left == 0) begin
               left = $urandom_range(20, 120);
               brisk = ($urandom_range(0, 3) == 0);
            end
            left--;
            hold = brisk ? 0 : $urandom_range(0, 8);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      phase_type ph;
      int unsigned random_start;
      thresh_result_type want;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OPENING_ROWS[i])
         feed_pixel(OPENING_ROWS[i].pixel, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);
      req_valid <= 1'b0;
      wait_drained();

      foreach (FRAME_PLAN[i]) begin
         if (i == 4) hold_off_request = 1'b1;
         run_phase(FRAME_PLAN[i]);
      end

      random_start = pixels_fed;
      while (pixels_fed - random_start < RANDOM_ITEMS) begin
         ph.length = 10'($urandom_range(9, 40));
         ph.rows = 10'($urandom_range(9, 14));
         case ($urandom_range(0, 2))
            0: ph.offset = 8'($urandom_range(0, 30));
            1: ph.offset = 8'($urandom_range(0, 255));
            default: ph.offset = '0;
         endcase
         ph.count = 12'($urandom_range(ph.length * ph.rows / 2, 2 * ph.length * ph.rows));
         ph.style = pix_style_type'($urandom_range(0, 3));
         run_phase(ph);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      while (expected_pixels.size() != 0) begin
         want = expected_pixels.pop_front();
         log_failure("item never arrived", want, BORDER);
      end
      $display("Fed %0d pixels under %0d register settings, row lengths 1 to 256, up to 1023 rows.",
               pixels_fed, settings_run);
      $display("Checked %0d items: %0d with a full window, %0d of all items set to 255.",
               items_checked, windows_seen, ones_seen);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("Timed out waiting for the core");
      $display("Mismatches found");
      $finish;
   end

endmodule
